// ===== rtl/vehicle_attitude_drive_controller_top_defines.svh =====
// assertion macros shared by the attitude and drive controller rtl
`ifndef VEHICLE_ATTITUDE_DRIVE_CONTROLLER_TOP_DEFINES_SVH
`define VEHICLE_ATTITUDE_DRIVE_CONTROLLER_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define VADC_ASSERT_IMPLY(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define VADC_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vadc_pkg.sv =====
// shared types, constants and fixed point helpers of the attitude and drive controller
`default_nettype none

package vadc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = 32;
    localparam int IN_W      = 304;
    localparam int OUT_W     = 192;
    localparam int SQ_IN_W   = FX_W + FRAC_BITS;
    localparam int SQ_ROOT_W = (SQ_IN_W + 1) / 2;
    localparam int L_SQ      = SQ_ROOT_W;
    localparam int L_DV      = FX_W;

    typedef logic signed [FX_W-1:0] t_fx;

    localparam t_fx FX_MAX   = t_fx'(64'sd2147483647);
    localparam t_fx FX_MIN   = t_fx'(-64'sd2147483647 - 64'sd1);
    localparam t_fx SMALL_FX = t_fx'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [63:0] ONE_W = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] W_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN = -64'sd2147483647 - 64'sd1;

    localparam logic [30:0] BANK_RST = 31'd9830;
    localparam logic [30:0] GRIP_RST = 31'd32768000;
    localparam logic [30:0] DRAG_RST = 31'd655360;

    typedef enum logic [2:0] {
        CFG_ATTACHED,
        CFG_PROP_GAIN,
        CFG_DAMP_GAIN,
        CFG_THRUST,
        CFG_YAW_RATE,
        CFG_BANK,
        CFG_GRIP,
        CFG_DRAG
    } t_cfg_idx;

    function automatic t_fx sat32(input logic signed [63:0] v);
        if (v > W_MAX) return FX_MAX;
        if (v < W_MIN) return FX_MIN;
        return t_fx'(v);
    endfunction

    function automatic t_fx fadd(input t_fx a, input t_fx b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic t_fx fsub(input t_fx a, input t_fx b);
        return sat32(64'(a) - 64'(b));
    endfunction

    function automatic t_fx fneg(input t_fx a);
        return sat32(-64'(a));
    endfunction

    // floor of the scaled product
    function automatic t_fx fmul(input t_fx a, input t_fx b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(p >>> FRAC_BITS);
    endfunction

    function automatic t_fx axis2(input logic signed [63:0] p, input logic signed [63:0] q);
        logic signed [63:0] s;
        s = p + q;
        return sat32(s >>> (FRAC_BITS - 1));
    endfunction

    function automatic t_fx axis1(input logic signed [63:0] p, input logic signed [63:0] q);
        logic signed [63:0] s;
        s = p + q;
        return sat32(ONE_W - (s >>> (FRAC_BITS - 1)));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vadc_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none

module vadc_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [vadc_pkg::SQ_IN_W-1:0]   i_rad,
    output logic [vadc_pkg::SQ_ROOT_W-1:0] o_root
);
    import vadc_pkg::*;

    logic [SQ_IN_W-1:0] r_v   [SQ_ROOT_W];
    logic [SQ_IN_W-1:0] r_res [SQ_ROOT_W];
    logic [SQ_IN_W-1:0] n_v   [SQ_ROOT_W];
    logic [SQ_IN_W-1:0] n_res [SQ_ROOT_W];

    function automatic logic [2*SQ_IN_W-1:0] root_step(input logic [SQ_IN_W-1:0] v,
                                                        input logic [SQ_IN_W-1:0] res,
                                                        input logic [SQ_IN_W-1:0] bitv);
        logic [SQ_IN_W:0] trial;
        trial = {1'b0, res} + {1'b0, bitv};
        if ({1'b0, v} >= trial) begin
            return {v - trial[SQ_IN_W-1:0], (res >> 1) + bitv};
        end
        return {v, res >> 1};
    endfunction

    always_comb begin
        {n_v[0], n_res[0]} = root_step(i_rad, '0, SQ_IN_W'(1) << (2 * (SQ_ROOT_W - 1)));
        for (int k = 1; k < SQ_ROOT_W; k++) begin
            {n_v[k], n_res[k]} = root_step(r_v[k-1], r_res[k-1],
                                           SQ_IN_W'(1) << (2 * (SQ_ROOT_W - 1 - k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_ROOT_W; k++) begin
                r_v[k]   <= n_v[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_root = r_res[SQ_ROOT_W-1][SQ_ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/vadc_div.sv =====
// pipelined signed fixed point divide by a positive speed, one quotient bit per stage
`default_nettype none

module vadc_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  vadc_pkg::t_fx                  i_num,
    input  logic [vadc_pkg::SQ_ROOT_W-1:0] i_den,
    output vadc_pkg::t_fx                  o_quo
);
    import vadc_pkg::*;

    localparam int N_W = FX_W + FRAC_BITS;
    localparam int CW  = SQ_ROOT_W + FX_W;
    localparam int QB  = FX_W - 1;

    typedef struct packed {
        logic                 neg;
        logic                 sat;
        logic [N_W-1:0]       rem;
        logic [QB-1:0]        quo;
        logic [SQ_ROOT_W-1:0] den;
    } t_dv;

    t_dv r_st [FX_W];
    t_dv n_st [FX_W];
    t_dv last;
    logic [FX_W-1:0] mag;

    function automatic t_dv div_step(input t_dv s, input int b);
        logic [CW-1:0] dsh;
        t_dv o;
        o   = s;
        dsh = CW'(s.den) << b;
        if (CW'(s.rem) >= dsh) begin
            o.rem = s.rem - dsh[N_W-1:0];
            o.quo = s.quo | (QB'(1) << b);
        end
        return o;
    endfunction

    always_comb begin
        // magnitude of the most negative value still fits unsigned
        mag          = i_num[FX_W-1] ? FX_W'(-i_num) : FX_W'(i_num);
        n_st[0].neg  = i_num[FX_W-1];
        n_st[0].rem  = {mag, FRAC_BITS'(0)};
        n_st[0].quo  = '0;
        n_st[0].den  = i_den;
        n_st[0].sat  = CW'({mag, FRAC_BITS'(0)}) >= (CW'(i_den) << QB);
        for (int k = 1; k < FX_W; k++) begin
            n_st[k] = div_step(r_st[k-1], QB - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < FX_W; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        last = r_st[FX_W-1];
        if (last.sat) begin
            o_quo = last.neg ? FX_MIN : FX_MAX;
        end else if (last.neg) begin
            o_quo = -t_fx'({1'b0, last.quo});
        end else begin
            o_quo = t_fx'({1'b0, last.quo});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vehicle_attitude_drive_controller_top.sv =====
// top level of the vehicle attitude and drive controller pipeline
// One word in and one word out per body per tick, at a sustained rate of one word per
// clock while the output is not stalled. Eight arithmetic stages form the axes, the
// torques and the thrust and grip forces, a 24-stage square root forms the speed, three
// 32-stage dividers normalise the velocity, and three stages apply drag and register the
// result. A stall on the output holds the whole pipeline in place; nothing is dropped.
// The user writes the configuration port only while the pipeline is empty; the block
// itself does not enforce this. With no body attached the result word is all zero.
`default_nettype none
`include "vehicle_attitude_drive_controller_top_defines.svh"

module vehicle_attitude_drive_controller_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [30:0]                  i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, spin_x, spin_y, spin_z, vel_x, vel_y, vel_z,
    // throttle_cmd, steer_cmd, zero pad
    input  logic [vadc_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // torque_x, torque_y, torque_z, force_x, force_y, force_z
    output logic [vadc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import vadc_pkg::*;

    localparam int D_SIDE = L_SQ + L_DV;

    typedef struct packed {
        logic vld;
        logic signed [35:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
        t_fx sbank, syaw, wxd, wzd, vxx, vyy, vzz, wy, vx, vy, vz, thr;
        logic thr_on;
        t_fx up_x, up_z, fw_x, fw_z, rt_x, rt_y, rt_z, roll_tgt, yaw_err, sq_a;
        t_fx t0m, t1m, dx, sq, lx, ly, lz, thx, thz;
        t_fx tq0, tq1, t2m, tq2, lat_a, nlat, mag, thfx, thfz, dmag;
        logic drag_on;
        t_fx gx, gy, gz;
        logic grip_on;
        t_fx fx, fy, fz;
    } t_stage;

    typedef struct packed {
        logic vld;
        t_fx  tq0, tq1, tq2, fx, fy, fz, dmag;
        logic drag_on;
    } t_side;

    typedef struct packed {
        t_fx vx, vy, vz;
    } t_vel;

    logic        r_attached;
    logic [30:0] r_kp, r_kd, r_thrust, r_yaw, r_bank, r_grip, r_drag;

    t_stage r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    t_stage n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
    t_side  r_sd [D_SIDE];
    t_side  n_side;
    t_vel   r_vd [L_SQ];
    t_side  r_sa, r_sb;
    t_fx    r_nq [3];
    t_fx    r_dr [3];
    t_fx    r_out [6];
    t_fx    n_out [6];
    logic   r_vo;

    logic pipe_en;
    t_fx  kp, kp_half, kd, thrust, yaw, bank, grip, drag;
    logic signed [17:0] in_qx, in_qy, in_qz, in_qw, in_thr, in_steer;
    t_fx  in_wx, in_wy, in_wz, in_vx, in_vy, in_vz;
    logic [SQ_IN_W-1:0]   rad;
    logic [SQ_ROOT_W-1:0] speed;
    t_fx  quo [3];

    assign pipe_en       = !r_vo || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_out[5], r_out[4], r_out[3], r_out[2], r_out[1], r_out[0]};

    assign kp      = {1'b0, r_kp};
    assign kp_half = {2'b00, r_kp[30:1]};
    assign kd      = {1'b0, r_kd};
    assign thrust  = {1'b0, r_thrust};
    assign yaw     = {1'b0, r_yaw};
    assign bank    = {1'b0, r_bank};
    assign grip    = {1'b0, r_grip};
    assign drag    = {1'b0, r_drag};

    assign in_qx    = s_axis_tdata[17:0];
    assign in_qy    = s_axis_tdata[35:18];
    assign in_qz    = s_axis_tdata[53:36];
    assign in_qw    = s_axis_tdata[71:54];
    assign in_wx    = s_axis_tdata[103:72];
    assign in_wy    = s_axis_tdata[135:104];
    assign in_wz    = s_axis_tdata[167:136];
    assign in_vx    = s_axis_tdata[199:168];
    assign in_vy    = s_axis_tdata[231:200];
    assign in_vz    = s_axis_tdata[263:232];
    assign in_thr   = s_axis_tdata[281:264];
    assign in_steer = s_axis_tdata[299:282];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached <= 1'b0;
            r_kp       <= '0;
            r_kd       <= '0;
            r_thrust   <= '0;
            r_yaw      <= '0;
            r_bank     <= BANK_RST;
            r_grip     <= GRIP_RST;
            r_drag     <= DRAG_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ATTACHED:  r_attached <= i_cfg_data[0];
                CFG_PROP_GAIN: r_kp       <= i_cfg_data;
                CFG_DAMP_GAIN: r_kd       <= i_cfg_data;
                CFG_THRUST:    r_thrust   <= i_cfg_data;
                CFG_YAW_RATE:  r_yaw      <= i_cfg_data;
                CFG_BANK:      r_bank     <= i_cfg_data;
                CFG_GRIP:      r_grip     <= i_cfg_data;
                CFG_DRAG:      r_drag     <= i_cfg_data;
            endcase
        end
    end

    // quaternion products and first scalings
    always_comb begin
        n_s1        = '0;
        n_s1.vld    = s_axis_tvalid;
        n_s1.p_xx   = in_qx * in_qx;
        n_s1.p_yy   = in_qy * in_qy;
        n_s1.p_zz   = in_qz * in_qz;
        n_s1.p_xy   = in_qx * in_qy;
        n_s1.p_xz   = in_qx * in_qz;
        n_s1.p_yz   = in_qy * in_qz;
        n_s1.p_wx   = in_qw * in_qx;
        n_s1.p_wy   = in_qw * in_qy;
        n_s1.p_wz   = in_qw * in_qz;
        n_s1.sbank  = fmul(t_fx'(in_steer), bank);
        n_s1.syaw   = fmul(t_fx'(in_steer), yaw);
        n_s1.wxd    = fmul(in_wx, kd);
        n_s1.wzd    = fmul(in_wz, kd);
        n_s1.vxx    = fmul(in_vx, in_vx);
        n_s1.vyy    = fmul(in_vy, in_vy);
        n_s1.vzz    = fmul(in_vz, in_vz);
        n_s1.wy     = in_wy;
        n_s1.vx     = in_vx;
        n_s1.vy     = in_vy;
        n_s1.vz     = in_vz;
        n_s1.thr    = t_fx'(in_thr);
        n_s1.thr_on = (t_fx'(in_thr) > SMALL_FX) || (t_fx'(in_thr) < -SMALL_FX);
    end

    // body axes
    always_comb begin
        n_s2          = r_s1;
        n_s2.up_x     = axis2(64'(r_s1.p_xy), -64'(r_s1.p_wz));
        n_s2.up_z     = axis2(64'(r_s1.p_yz), 64'(r_s1.p_wx));
        n_s2.fw_x     = axis2(64'(r_s1.p_xz), 64'(r_s1.p_wy));
        n_s2.fw_z     = axis1(64'(r_s1.p_xx), 64'(r_s1.p_yy));
        n_s2.rt_x     = axis1(64'(r_s1.p_yy), 64'(r_s1.p_zz));
        n_s2.rt_y     = axis2(64'(r_s1.p_xy), 64'(r_s1.p_wz));
        n_s2.rt_z     = axis2(64'(r_s1.p_xz), -64'(r_s1.p_wy));
        n_s2.roll_tgt = fneg(r_s1.sbank);
        n_s2.yaw_err  = fsub(r_s1.syaw, r_s1.wy);
        n_s2.sq_a     = fadd(r_s1.vxx, r_s1.vyy);
    end

    always_comb begin
        n_s3     = r_s2;
        n_s3.t0m = fmul(fneg(r_s2.up_z), kp);
        n_s3.t1m = fmul(r_s2.yaw_err, kp_half);
        n_s3.dx  = fsub(r_s2.up_x, r_s2.roll_tgt);
        n_s3.sq  = fadd(r_s2.sq_a, r_s2.vzz);
        n_s3.lx  = fmul(r_s2.vx, r_s2.rt_x);
        n_s3.ly  = fmul(r_s2.vy, r_s2.rt_y);
        n_s3.lz  = fmul(r_s2.vz, r_s2.rt_z);
        n_s3.thx = fmul(r_s2.fw_x, r_s2.thr);
        n_s3.thz = fmul(r_s2.fw_z, r_s2.thr);
    end

    always_comb begin
        n_s4         = r_s3;
        n_s4.tq0     = fsub(r_s3.t0m, r_s3.wxd);
        n_s4.tq1     = r_s3.t1m;
        n_s4.t2m     = fmul(r_s3.dx, kp);
        n_s4.lat_a   = fadd(r_s3.lx, r_s3.ly);
        n_s4.thfx    = fmul(r_s3.thx, thrust);
        n_s4.thfz    = fmul(r_s3.thz, thrust);
        n_s4.dmag    = fmul(r_s3.sq, drag);
        n_s4.drag_on = r_s3.sq > SMALL_FX;
    end

    always_comb begin
        n_s5      = r_s4;
        n_s5.tq2  = fsub(r_s4.t2m, r_s4.wzd);
        n_s5.nlat = fneg(fadd(r_s4.lat_a, r_s4.lz));
    end

    always_comb begin
        n_s6     = r_s5;
        n_s6.mag = fmul(r_s5.nlat, grip);
    end

    always_comb begin
        n_s7         = r_s6;
        n_s7.gx      = fmul(r_s6.rt_x, r_s6.mag);
        n_s7.gy      = fmul(r_s6.rt_y, r_s6.mag);
        n_s7.gz      = fmul(r_s6.rt_z, r_s6.mag);
        n_s7.grip_on = (r_s6.mag > SMALL_FX) || (r_s6.mag < -SMALL_FX);
    end

    // thrust plus grip
    always_comb begin
        n_s8    = r_s7;
        n_s8.fx = fadd(r_s7.thr_on ? r_s7.thfx : '0, r_s7.grip_on ? r_s7.gx : '0);
        n_s8.fy = r_s7.grip_on ? r_s7.gy : '0;
        n_s8.fz = fadd(r_s7.thr_on ? r_s7.thfz : '0, r_s7.grip_on ? r_s7.gz : '0);
    end

    always_comb begin
        n_side.vld     = r_s8.vld;
        n_side.tq0     = r_s8.tq0;
        n_side.tq1     = r_s8.tq1;
        n_side.tq2     = r_s8.tq2;
        n_side.fx      = r_s8.fx;
        n_side.fy      = r_s8.fy;
        n_side.fz      = r_s8.fz;
        n_side.dmag    = r_s8.dmag;
        n_side.drag_on = r_s8.drag_on;
    end

    // speed of the sum of squares scaled up by one
    assign rad = SQ_IN_W'({r_s8.sq[FX_W-2:0], FRAC_BITS'(0)});

    vadc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_rad  (rad),
        .o_root (speed)
    );

    vadc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_vd[L_SQ-1].vx),
        .i_den (speed),
        .o_quo (quo[0])
    );

    vadc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_vd[L_SQ-1].vy),
        .i_den (speed),
        .o_quo (quo[1])
    );

    vadc_div u_div_z (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_vd[L_SQ-1].vz),
        .i_den (speed),
        .o_quo (quo[2])
    );

    // drag added last, detached body gives zero
    always_comb begin
        n_out[0] = r_sb.tq0;
        n_out[1] = r_sb.tq1;
        n_out[2] = r_sb.tq2;
        n_out[3] = fadd(r_sb.fx, r_sb.drag_on ? r_dr[0] : '0);
        n_out[4] = fadd(r_sb.fy, r_sb.drag_on ? r_dr[1] : '0);
        n_out[5] = fadd(r_sb.fz, r_sb.drag_on ? r_dr[2] : '0);
        if (!r_attached) begin
            for (int k = 0; k < 6; k++) begin
                n_out[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
            r_s4.vld <= 1'b0;
            r_s5.vld <= 1'b0;
            r_s6.vld <= 1'b0;
            r_s7.vld <= 1'b0;
            r_s8.vld <= 1'b0;
            for (int k = 0; k < D_SIDE; k++) begin
                r_sd[k].vld <= 1'b0;
            end
            r_sa.vld <= 1'b0;
            r_sb.vld <= 1'b0;
            r_vo     <= 1'b0;
        end else if (pipe_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
            r_sd[0] <= n_side;
            for (int k = 1; k < D_SIDE; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_vd[0] <= '{vx: r_s8.vx, vy: r_s8.vy, vz: r_s8.vz};
            for (int k = 1; k < L_SQ; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_sa <= r_sd[D_SIDE-1];
            r_sb <= r_sa;
            for (int k = 0; k < 3; k++) begin
                r_nq[k] <= fneg(quo[k]);
                r_dr[k] <= fmul(r_nq[k], r_sa.dmag);
            end
            for (int k = 0; k < 6; k++) begin
                r_out[k] <= n_out[k];
            end
            r_vo <= r_sb.vld;
        end
    end

    `VADC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_s1.vld, "accepted word missing from first stage")
    `VADC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !pipe_en, $stable(r_s8.vld) && $stable(r_sa.vld), "pipeline moved during stall")
    `VADC_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, pipe_en && r_sb.vld, m_axis_tvalid, "final stage word not presented")

endmodule

`default_nettype wire

// ===== tb/tb_vehicle_attitude_drive_controller_top.sv =====
// self-checking testbench of the attitude and drive controller, with a bit-exact predictor
`default_nettype none

module tb_vehicle_attitude_drive_controller_top;
    import vadc_pkg::*;

    localparam int PIPE_LAT = 67;

    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        logic signed [17:0] steer;
        logic signed [17:0] throttle;
        logic signed [31:0] vz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
        logic signed [31:0] wz;
        logic signed [31:0] wy;
        logic signed [31:0] wx;
        logic signed [17:0] qw;
        logic signed [17:0] qz;
        logic signed [17:0] qy;
        logic signed [17:0] qx;
    } t_body;

    typedef struct packed {
        t_fx force_z;
        t_fx force_y;
        t_fx force_x;
        t_fx torque_z;
        t_fx torque_y;
        t_fx torque_x;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    // controller settings as the predictor sees them
    logic attached;
    t_wide kp, kd, thrust_k, yaw_k, bank_k, grip_k, drag_k;

    t_drive drive_queue[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    bit sink_hold = 1'b0;
    bit calm = 1'b0;

    vehicle_attitude_drive_controller_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #40000000;
        $display("[vehicle_attitude_drive_controller_top] ERROR");
        $finish;
    end

    function automatic t_wide clip(input t_wide v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_wide qmul(input t_wide a, input t_wide b);
        return clip((a * b) >>> FRAC_BITS);
    endfunction

    function automatic t_wide qdiv(input t_wide a, input t_wide b);
        if (b == 0) return 0;
        return clip((a <<< FRAC_BITS) / b);
    endfunction

    function automatic t_wide root_floor(input logic [63:0] v);
        logic [63:0] r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return t_wide'(r);
    endfunction

    function automatic t_drive predict_drive(input t_body b);
        t_drive d;
        t_wide one, eps, qx, qy, qz, qw, up_x, up_z, fw_x, fw_z, rt_x, rt_y, rt_z;
        t_wide roll_tgt, fx, fy, fz, lat, mag, sq, spd, dmag, thr, thr_abs, mag_abs;
        d = '0;
        one = t_wide'(1) <<< FRAC_BITS;
        eps = ((t_wide'(1) <<< FRAC_BITS) + 50) / 100;
        if (!attached) return d;
        qx = t_wide'(b.qx); qy = t_wide'(b.qy); qz = t_wide'(b.qz); qw = t_wide'(b.qw);
        up_x = clip((2 * (qx * qy - qw * qz)) >>> FRAC_BITS);
        up_z = clip((2 * (qy * qz + qw * qx)) >>> FRAC_BITS);
        fw_x = clip((2 * (qx * qz + qw * qy)) >>> FRAC_BITS);
        fw_z = clip(one - ((2 * (qx * qx + qy * qy)) >>> FRAC_BITS));
        rt_x = clip(one - ((2 * (qy * qy + qz * qz)) >>> FRAC_BITS));
        rt_y = clip((2 * (qx * qy + qw * qz)) >>> FRAC_BITS);
        rt_z = clip((2 * (qx * qz - qw * qy)) >>> FRAC_BITS);
        roll_tgt = clip(-qmul(t_wide'(b.steer), bank_k));
        d.torque_x = t_fx'(clip(qmul(clip(-up_z), kp) - qmul(t_wide'(b.wx), kd)));
        d.torque_y = t_fx'(qmul(clip(qmul(t_wide'(b.steer), yaw_k) - t_wide'(b.wy)),
                                kp >>> 1));
        d.torque_z = t_fx'(clip(qmul(clip(up_x - roll_tgt), kp) - qmul(t_wide'(b.wz), kd)));
        fx = 0; fy = 0; fz = 0;
        thr = t_wide'(b.throttle);
        thr_abs = thr < 0 ? -thr : thr;
        if (thr_abs > eps) begin
            fx = clip(fx + qmul(qmul(fw_x, thr), thrust_k));
            fz = clip(fz + qmul(qmul(fw_z, thr), thrust_k));
        end
        lat = clip(clip(qmul(t_wide'(b.vx), rt_x) + qmul(t_wide'(b.vy), rt_y))
                   + qmul(t_wide'(b.vz), rt_z));
        mag = qmul(clip(-lat), grip_k);
        mag_abs = mag < 0 ? -mag : mag;
        if (mag_abs > eps) begin
            fx = clip(fx + qmul(rt_x, mag));
            fy = clip(fy + qmul(rt_y, mag));
            fz = clip(fz + qmul(rt_z, mag));
        end
        sq = clip(clip(qmul(t_wide'(b.vx), t_wide'(b.vx)) + qmul(t_wide'(b.vy), t_wide'(b.vy)))
                  + qmul(t_wide'(b.vz), t_wide'(b.vz)));
        if (sq > eps) begin
            spd = root_floor(64'(sq) << FRAC_BITS);
            dmag = qmul(sq, drag_k);
            fx = clip(fx + qmul(clip(-qdiv(t_wide'(b.vx), spd)), dmag));
            fy = clip(fy + qmul(clip(-qdiv(t_wide'(b.vy), spd)), dmag));
            fz = clip(fz + qmul(clip(-qdiv(t_wide'(b.vz), spd)), dmag));
        end
        d.force_x = t_fx'(fx); d.force_y = t_fx'(fy); d.force_z = t_fx'(fz);
        return d;
    endfunction

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input t_cfg_idx idx, input logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ATTACHED:  attached = val[0];
            CFG_PROP_GAIN: kp = t_wide'(val);
            CFG_DAMP_GAIN: kd = t_wide'(val);
            CFG_THRUST:    thrust_k = t_wide'(val);
            CFG_YAW_RATE:  yaw_k = t_wide'(val);
            CFG_BANK:      bank_k = t_wide'(val);
            CFG_GRIP:      grip_k = t_wide'(val);
            default:       drag_k = t_wide'(val);
        endcase
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    // offers one word, idling now and then; valid stays high between back-to-back words
    task automatic send_body(input t_body b, input bit has_ref, input t_drive ref_d);
        while (!calm && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(b);
        do @(posedge i_clk); while (!s_axis_tready);
        drive_queue.push_back(has_ref ? ref_d : predict_drive(b));
        words_in++;
    endtask

    function automatic logic signed [17:0] rand_unit();
        case ($urandom_range(5))
            0: return -18'sd65536;
            1: return 18'sd65536;
            2: return 18'sd0;
            3: return 18'($urandom);
            default: return 18'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_speed();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(1000)) - 500);
            3: return $urandom;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic t_body rand_body();
        t_body b;
        int unsigned a;
        a = $urandom_range(65536);
        // mostly rotations about a single axis, not always of unit norm, the rest anything
        if ($urandom_range(3) != 0) begin
            b.qx = 0; b.qy = 0; b.qz = 0;
            b.qw = 18'(a);
            case ($urandom_range(2))
                0: b.qx = 18'($urandom_range(1) ? 65536 - a : a - 65536);
                1: b.qy = 18'($urandom_range(1) ? 65536 - a : a - 65536);
                default: b.qz = 18'($urandom_range(1) ? 65536 - a : a - 65536);
            endcase
        end else begin
            b.qx = rand_unit(); b.qy = rand_unit(); b.qz = rand_unit(); b.qw = rand_unit();
        end
        b.wx = rand_speed(); b.wy = rand_speed(); b.wz = rand_speed();
        b.vx = rand_speed(); b.vy = rand_speed(); b.vz = rand_speed();
        b.throttle = rand_unit();
        b.steer = rand_unit();
        return b;
    endfunction

    function automatic logic [30:0] rand_gain();
        case ($urandom_range(4))
            0: return 31'h7fffffff;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(20 * 65536));
        endcase
    endfunction

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !sink_hold && (calm || $urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        t_drive got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_drive'(m_axis_tdata);
            words_out++;
            if (drive_queue.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = drive_queue.pop_front();
                if (got.torque_x !== want.torque_x) begin
                    $error("torque_x exp %0d got %0d", want.torque_x, got.torque_x); errors++;
                end
                if (got.torque_y !== want.torque_y) begin
                    $error("torque_y exp %0d got %0d", want.torque_y, got.torque_y); errors++;
                end
                if (got.torque_z !== want.torque_z) begin
                    $error("torque_z exp %0d got %0d", want.torque_z, got.torque_z); errors++;
                end
                if (got.force_x !== want.force_x) begin
                    $error("force_x exp %0d got %0d", want.force_x, got.force_x); errors++;
                end
                if (got.force_y !== want.force_y) begin
                    $error("force_y exp %0d got %0d", want.force_y, got.force_y); errors++;
                end
                if (got.force_z !== want.force_z) begin
                    $error("force_z exp %0d got %0d", want.force_z, got.force_z); errors++;
                end
            end
        end
    end

    typedef struct {
        t_body b;
        bit has_ref;
    } t_row;

    initial begin
        t_row rows[$];
        t_body b;
        int n;
        attached = 1'b0;
        kp = 0; kd = 0; thrust_k = 0; yaw_k = 0;
        bank_k = 9830; grip_k = 32768000; drag_k = 655360;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // detached after reset: all-zero word whatever the input
        b = {18'sd65536, -18'sd65536, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             18'sd65536, -18'sd65536, 18'sd65536, -18'sd65536};
        rows.push_back('{b, 1'b1});
        rows.push_back('{'1, 1'b1});
        foreach (rows[r]) send_body(rows[r].b, rows[r].has_ref, '0);
        drain_pipe();

        write_reg(CFG_ATTACHED, 31'd1);
        write_reg(CFG_PROP_GAIN, 31'd3 << 16);
        write_reg(CFG_DAMP_GAIN, 31'd1 << 15);
        write_reg(CFG_THRUST, 31'd50 << 16);
        write_reg(CFG_YAW_RATE, 31'd2 << 16);
        i_cfg_we <= 1'b0;
        rows.delete();
        // identity at rest, throttle in and out of the deadband, slow and fast bodies
        b = '0; b.qw = 18'sd65536;
        rows.push_back('{b, 1'b1});
        b.throttle = 18'sd655; rows.push_back('{b, 1'b0});
        b.throttle = 18'sd656; rows.push_back('{b, 1'b0});
        b.throttle = -18'sd65536; rows.push_back('{b, 1'b0});
        b.vx = 32'sd6000; rows.push_back('{b, 1'b0});
        b.vx = 32'sd60000; rows.push_back('{b, 1'b0});
        b.vx = 32'sh7fffffff; b.vz = 32'sh80000000; rows.push_back('{b, 1'b0});
        b.vx = 0; b.vz = 0; b.vy = 32'sd100; rows.push_back('{b, 1'b0});
        b.steer = 18'sd65536; b.wy = 32'sh80000000; rows.push_back('{b, 1'b0});
        b.steer = -18'sd65536; b.wx = 32'sh7fffffff; b.wz = 32'sh80000000;
        rows.push_back('{b, 1'b0});
        b = '0; b.qx = 18'sd65536; b.vz = 32'sd200000; rows.push_back('{b, 1'b0});
        b = '0; b.qy = -18'sd65536; b.qz = 18'sd65536; b.vx = -32'sd90000;
        rows.push_back('{b, 1'b0});
        // non-unit quaternion at the corners
        b.qx = -18'sd131072; b.qy = 18'sd131071; b.qz = -18'sd131072; b.qw = 18'sd131071;
        b.throttle = 18'sd131071; b.steer = -18'sd131072;
        rows.push_back('{b, 1'b0});
        rows.push_back('{'1, 1'b0});
        foreach (rows[r]) send_body(rows[r].b, rows[r].has_ref, '0);
        drain_pipe();

        // random phases with fresh settings, the extremes among them
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_ATTACHED, (ph == 3) ? 31'd0 : 31'($urandom) | 31'd1);
            write_reg(CFG_PROP_GAIN, ph == 1 ? 31'h7fffffff : rand_gain());
            write_reg(CFG_DAMP_GAIN, ph == 1 ? 31'h7fffffff : rand_gain());
            write_reg(CFG_THRUST, ph == 2 ? 31'h7fffffff : rand_gain());
            write_reg(CFG_YAW_RATE, ph == 2 ? 31'd0 : rand_gain());
            write_reg(CFG_BANK, ph == 1 ? 31'h7fffffff : rand_gain());
            write_reg(CFG_GRIP, ph == 2 ? 31'd0 : rand_gain());
            write_reg(CFG_DRAG, ph == 1 ? 31'h7fffffff : rand_gain());
            i_cfg_we <= 1'b0;
            calm = (ph == 5);
            n = (ph == 4) ? 104 : 40;
            if (ph == 4) begin
                // sink holds off while words keep coming so the input stalls
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (300) @(posedge i_clk);
                        sink_hold = 1'b0;
                    end
                    for (int k = 0; k < n; k++) send_body(rand_body(), 1'b0, '0);
                join
            end else begin
                for (int k = 0; k < n; k++) begin
                    send_body(rand_body(), 1'b0, '0);
                    // one pause until the pipeline has emptied
                    if (ph == 6 && k == 20) begin
                        s_axis_tvalid <= 1'b0;
                        while (drive_queue.size() != 0) @(posedge i_clk);
                    end
                end
            end
            calm = 1'b0;
            drain_pipe();
        end

        $display("covered %0d words in, %0d out, over ten register settings", words_in,
                 words_out);
        $display("including detached, saturating, deadband and stalled-output cases");
        if (errors == 0) begin
            $display("[vehicle_attitude_drive_controller_top] OK");
        end else begin
            $display("[vehicle_attitude_drive_controller_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== vehicle_attitude_drive_controller_top.f =====
+incdir+rtl
rtl/vadc_pkg.sv
rtl/vadc_sqrt.sv
rtl/vadc_div.sv
rtl/vehicle_attitude_drive_controller_top.sv
tb/tb_vehicle_attitude_drive_controller_top.sv
